// File: hdl/bom_pkg.sv
// Shared constants and types for the billboard orientation matrix block.
`default_nettype none

package bom_pkg;

  // Width of one data word (positions, scales and matrix entries).
  localparam int WORD_W = 32;

  // Magnitudes are normalized so that the largest has its top bit here.
  localparam int NMAG_W = 30;

  // Width of a bit position within a magnitude.
  localparam int POS_W = 6;

  // Sum of three squared normalized magnitudes, and its square root.
  localparam int LEN2_W = 2 * NMAG_W + 2;
  localparam int LEN_W = NMAG_W + 1;

  // One square root step per result bit.
  localparam int SQRT_STEPS = LEN_W;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z = 2'd2;

  // Axis lock selection for the object-to-camera vector.
  typedef enum logic [1:0] {
    LOCK_FREE = 2'd0,
    LOCK_X    = 2'd1,
    LOCK_Y    = 2'd2,
    LOCK_Z    = 2'd3
  } lock_mode_t;

endpackage

`default_nettype wire

// File: hdl/bom_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module bom_isqrt #(
  parameter int SW = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [bom_pkg::LEN2_W-1:0]  in_n,
  input  logic [SW-1:0]               in_sb,
  output logic                        out_valid,
  output logic [bom_pkg::LEN_W-1:0]   out_root,
  output logic [SW-1:0]               out_sb
);

  localparam int STEPS = bom_pkg::SQRT_STEPS;
  localparam int AW = bom_pkg::LEN2_W + 2;

  logic [AW-1:0] rem_r [STEPS];
  logic [AW-1:0] res_r [STEPS];
  logic          v_r   [STEPS];
  logic [SW-1:0] sb_r  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [AW-1:0] BIT = AW'(1) << (2 * (STEPS - 1 - k));

    logic [AW-1:0] rem_c;
    logic [AW-1:0] res_c;
    logic          v_c;
    logic [SW-1:0] sb_c;
    logic [AW-1:0] trial;

    if (k == 0) begin : g_first
      assign rem_c = AW'(in_n);
      assign res_c = '0;
      assign v_c   = in_valid;
      assign sb_c  = in_sb;
    end else begin : g_next
      assign rem_c = rem_r[k-1];
      assign res_c = res_r[k-1];
      assign v_c   = v_r[k-1];
      assign sb_c  = sb_r[k-1];
    end

    assign trial = res_c + BIT;

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c;
      end
    end

    // One digit of the root: subtract the trial value when it fits.
    always_ff @(posedge clk) begin
      if (en) begin
        sb_r[k] <= sb_c;
        if (rem_c >= trial) begin
          rem_r[k] <= rem_c - trial;
          res_r[k] <= (res_c >> 1) + BIT;
        end else begin
          rem_r[k] <= rem_c;
          res_r[k] <= res_c >> 1;
        end
      end
    end
  end

  assign out_valid = v_r[STEPS-1];
  assign out_root  = res_r[STEPS-1][bom_pkg::LEN_W-1:0];
  assign out_sb    = sb_r[STEPS-1];

endmodule

`default_nettype wire

// File: hdl/bom_udiv.sv
// Pipelined restoring divider for three numerators over one shared divisor.
`default_nettype none

module bom_udiv #(
  parameter int FW = 16,
  parameter int SW = 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][bom_pkg::NMAG_W+FW:0]      in_num,
  input  logic [bom_pkg::LEN_W-1:0]             in_den,
  input  logic [SW-1:0]                         in_sb,
  output logic                                  out_valid,
  output logic [2:0][FW:0]                      out_q,
  output logic [SW-1:0]                         out_sb
);

  localparam int NUMW = bom_pkg::NMAG_W + FW + 1;
  localparam int DW = bom_pkg::LEN_W;
  localparam int QW = FW + 1;

  logic [2:0][NUMW-1:0] rem_r [QW];
  logic [2:0][QW-1:0]   q_r   [QW];
  logic [DW-1:0]        den_r [QW];
  logic                 v_r   [QW];
  logic [SW-1:0]        sb_r  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int SH = FW - k;

    logic [2:0][NUMW-1:0] rem_c;
    logic [2:0][QW-1:0]   q_c;
    logic [DW-1:0]        den_c;
    logic                 v_c;
    logic [SW-1:0]        sb_c;
    logic [NUMW-1:0]      dsh;

    if (k == 0) begin : g_first
      assign rem_c = in_num;
      assign q_c   = '0;
      assign den_c = in_den;
      assign v_c   = in_valid;
      assign sb_c  = in_sb;
    end else begin : g_next
      assign rem_c = rem_r[k-1];
      assign q_c   = q_r[k-1];
      assign den_c = den_r[k-1];
      assign v_c   = v_r[k-1];
      assign sb_c  = sb_r[k-1];
    end

    assign dsh = NUMW'(den_c) << SH;

    // Valid bit of this stage.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_c;
      end
    end

    // One quotient bit per lane.
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_c;
        sb_r[k]  <= sb_c;
        for (int j = 0; j < 3; j++) begin
          if (rem_c[j] >= dsh) begin
            rem_r[k][j] <= rem_c[j] - dsh;
            q_r[k][j]   <= q_c[j] | (QW'(1) << SH);
          end else begin
            rem_r[k][j] <= rem_c[j];
            q_r[k][j]   <= q_c[j];
          end
        end
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_sb    = sb_r[QW-1];

endmodule

`default_nettype wire

// File: hdl/bom_norm.sv
// Pipelined unit vector of three magnitudes: prescale, length, divide.
`default_nettype none

module bom_norm #(
  parameter int MW = 33,
  parameter int FW = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][MW-1:0]   in_mag,
  input  logic [SW-1:0]        in_sb,
  output logic                 out_valid,
  output logic [2:0][FW:0]     out_q,
  output logic                 out_zero,
  output logic [SW-1:0]        out_sb
);

  localparam int NW = bom_pkg::NMAG_W;
  localparam int PW = bom_pkg::POS_W;
  localparam int SQW = 2 * NW;
  localparam int L2W = bom_pkg::LEN2_W;
  localparam int LW = bom_pkg::LEN_W;
  localparam int NUMW = NW + FW + 1;
  localparam int XW = 64;
  localparam int RSW = 3 * NW + 1 + SW;
  localparam int DSW = 1 + SW;

  // Stage 1: find the top set bit over all three magnitudes.
  logic [MW-1:0] any_bits;
  logic [PW-1:0] msb_pos;

  always_comb begin
    any_bits = in_mag[0] | in_mag[1] | in_mag[2];
    msb_pos  = '0;
    for (int b = 0; b < MW; b++) begin
      if (any_bits[b]) begin
        msb_pos = PW'(b);
      end
    end
  end

  logic                s1_v_r;
  logic [2:0][MW-1:0]  s1_mag_r;
  logic [PW-1:0]       s1_pos_r;
  logic                s1_zero_r;
  logic [SW-1:0]       s1_sb_r;

  // Stage 2: shift all magnitudes together so the largest tops out at NW-1.
  logic [2:0][NW-1:0] nm;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (s1_pos_r >= PW'(NW - 1)) begin
        nm[j] = NW'(XW'(s1_mag_r[j]) >> (s1_pos_r - PW'(NW - 1)));
      end else begin
        nm[j] = NW'(XW'(s1_mag_r[j]) << (PW'(NW - 1) - s1_pos_r));
      end
    end
  end

  logic                s2_v_r;
  logic [2:0][NW-1:0]  s2_nm_r;
  logic                s2_zero_r;
  logic [SW-1:0]       s2_sb_r;

  // Stage 3: squares; stage 4: sum of squares.
  logic                s3_v_r;
  logic [2:0][SQW-1:0] s3_sq_r;
  logic [2:0][NW-1:0]  s3_nm_r;
  logic                s3_zero_r;
  logic [SW-1:0]       s3_sb_r;

  logic                s4_v_r;
  logic [L2W-1:0]      s4_len2_r;
  logic [2:0][NW-1:0]  s4_nm_r;
  logic                s4_zero_r;
  logic [SW-1:0]       s4_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r  <= in_mag;
      s1_pos_r  <= msb_pos;
      s1_zero_r <= ~|any_bits;
      s1_sb_r   <= in_sb;

      s2_nm_r   <= nm;
      s2_zero_r <= s1_zero_r;
      s2_sb_r   <= s1_sb_r;

      for (int j = 0; j < 3; j++) begin
        s3_sq_r[j] <= SQW'(s2_nm_r[j]) * SQW'(s2_nm_r[j]);
      end
      s3_nm_r   <= s2_nm_r;
      s3_zero_r <= s2_zero_r;
      s3_sb_r   <= s2_sb_r;

      s4_len2_r <= L2W'(s3_sq_r[0]) + L2W'(s3_sq_r[1]) + L2W'(s3_sq_r[2]);
      s4_nm_r   <= s3_nm_r;
      s4_zero_r <= s3_zero_r;
      s4_sb_r   <= s3_sb_r;
    end
  end

  // Length of the prescaled vector.
  logic                rt_v;
  logic [LW-1:0]       rt_root;
  logic [RSW-1:0]      rt_sb;
  logic [2:0][NW-1:0]  rt_nm;
  logic                rt_zero;
  logic [SW-1:0]       rt_sb_in;

  bom_isqrt #(
    .SW (RSW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_v_r),
    .in_n      (s4_len2_r),
    .in_sb     ({s4_nm_r, s4_zero_r, s4_sb_r}),
    .out_valid (rt_v),
    .out_root  (rt_root),
    .out_sb    (rt_sb)
  );

  assign {rt_nm, rt_zero, rt_sb_in} = rt_sb;

  // Stage 5: rounded numerators, magnitude scaled up plus half the length.
  logic                 s5_v_r;
  logic [2:0][NUMW-1:0] s5_num_r;
  logic [LW-1:0]        s5_len_r;
  logic                 s5_zero_r;
  logic [SW-1:0]        s5_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s5_num_r[j] <= (NUMW'(rt_nm[j]) << FW) + NUMW'(rt_root >> 1);
      end
      s5_len_r  <= rt_root;
      s5_zero_r <= rt_zero;
      s5_sb_r   <= rt_sb_in;
    end
  end

  // Unit components.
  logic [2:0][FW:0] dv_q;
  logic [DSW-1:0]   dv_sb;

  bom_udiv #(
    .FW (FW),
    .SW (DSW)
  ) u_udiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s5_v_r),
    .in_num    (s5_num_r),
    .in_den    (s5_len_r),
    .in_sb     ({s5_zero_r, s5_sb_r}),
    .out_valid (out_valid),
    .out_q     (dv_q),
    .out_sb    (dv_sb)
  );

  // A zero-length vector yields a zero unit vector.
  assign {out_zero, out_sb} = dv_sb;
  assign out_q = out_zero ? '0 : dv_q;

endmodule

`default_nettype wire

// File: hdl/billboard_orientation_matrix.sv
// Top level of the billboard orientation matrix pipeline.
`default_nettype none

// Builds the scaled camera-facing 3x3 rotation of one object per beat. The
// pipeline accepts one object every clock cycle unless it is held. Each of
// the two normalizations runs a one-bit-per-stage square root of 31 stages
// and a one-bit-per-stage divider of FRAC_BITS+1 stages. A two-entry output
// buffer keeps input accepted while one finished result waits; the whole
// pipeline holds only when both entries are full. Camera registers are
// written through the cfg port, which is always ready, and must only change
// while the block is idle.
module billboard_orientation_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bom_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bom_pkg::WORD_W-1:0]          cfg_data,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [bom_pkg::WORD_W-1:0]   in_obj_x,
  input  logic signed [bom_pkg::WORD_W-1:0]   in_obj_y,
  input  logic signed [bom_pkg::WORD_W-1:0]   in_obj_z,
  input  logic signed [bom_pkg::WORD_W-1:0]   in_scale_x,
  input  logic signed [bom_pkg::WORD_W-1:0]   in_scale_y,
  input  logic signed [bom_pkg::WORD_W-1:0]   in_scale_z,
  input  logic [1:0]                          in_lock_mode,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m00,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m01,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m02,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m10,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m11,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m12,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m20,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m21,
  output logic signed [bom_pkg::WORD_W-1:0]   out_m22,
  output logic                                out_degenerate
);

  localparam int WW = bom_pkg::WORD_W;
  localparam int FW = FRAC_BITS;
  localparam int QW = FW + 1;
  localparam int VW = FW + 2;
  localparam int UW = FW + 3;
  localparam int PPW = 2 * VW;
  localparam int MPW = WW + UW;
  localparam int DW = WW + 1;
  localparam int SB1_W = 3 * WW + 3;
  localparam int SB2_W = 3 * VW + 3 * WW + 3;
  localparam logic [MPW:0] HALF = (MPW + 1)'(1) << (FW - 1);

  // Rounded fixed-point rescale: add half an LSB, shift toward minus infinity.
  function automatic logic signed [MPW:0] rnd_shift(input logic [MPW-1:0] x);
    logic [MPW:0] t;
    t = {x[MPW-1], x} + HALF;
    return $signed(t) >>> FW;
  endfunction

  // Clamp to the signed word range.
  function automatic logic [WW-1:0] sat_word(input logic [MPW:0] v);
    logic [MPW-WW+1:0] hi;
    hi = v[MPW:WW-1];
    if ((&hi) || !(|hi)) begin
      return v[WW-1:0];
    end else if (v[MPW]) begin
      return {1'b1, {(WW - 1){1'b0}}};
    end else begin
      return {1'b0, {(WW - 1){1'b1}}};
    end
  endfunction

  // Pipeline advance and output buffer state.
  logic en;
  logic skid_v_r;
  logic out_v_r;

  assign en        = !skid_v_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Camera position registers.
  logic [WW-1:0] cam_x_r;
  logic [WW-1:0] cam_y_r;
  logic [WW-1:0] cam_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bom_pkg::REG_CAMERA_X: cam_x_r <= cfg_data;
        bom_pkg::REG_CAMERA_Y: cam_y_r <= cfg_data;
        bom_pkg::REG_CAMERA_Z: cam_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Object-to-camera vector with the locked axis cleared.
  logic [2:0][DW-1:0] diff;

  always_comb begin
    diff[0] = {cam_x_r[WW-1], cam_x_r} - {in_obj_x[WW-1], in_obj_x};
    diff[1] = {cam_y_r[WW-1], cam_y_r} - {in_obj_y[WW-1], in_obj_y};
    diff[2] = {cam_z_r[WW-1], cam_z_r} - {in_obj_z[WW-1], in_obj_z};
    unique case (bom_pkg::lock_mode_t'(in_lock_mode))
      bom_pkg::LOCK_FREE: ;
      bom_pkg::LOCK_X:    diff[0] = '0;
      bom_pkg::LOCK_Y:    diff[1] = '0;
      bom_pkg::LOCK_Z:    diff[2] = '0;
    endcase
  end

  logic               a_v_r;
  logic [2:0][DW-1:0] a_diff_r;
  logic [2:0][WW-1:0] a_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_diff_r  <= diff;
      a_scale_r <= {in_scale_z, in_scale_y, in_scale_x};
    end
  end

  // Sign and magnitude of the vector for the first normalization.
  logic [2:0][DW-1:0] a_mag;
  logic [2:0]         a_neg;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      a_neg[j] = a_diff_r[j][DW-1];
      a_mag[j] = a_neg[j] ? (~a_diff_r[j] + 1'b1) : a_diff_r[j];
    end
  end

  logic               n1_v;
  logic [2:0][FW:0]   n1_q;
  logic               n1_zero;
  logic [SB1_W-1:0]   n1_sb;
  logic [2:0][WW-1:0] n1_scale;
  logic [2:0]         n1_neg;

  bom_norm #(
    .MW (DW),
    .FW (FW),
    .SW (SB1_W)
  ) u_norm_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (a_v_r),
    .in_mag    (a_mag),
    .in_sb     ({a_scale_r, a_neg}),
    .out_valid (n1_v),
    .out_q     (n1_q),
    .out_zero  (n1_zero),
    .out_sb    (n1_sb)
  );

  assign {n1_scale, n1_neg} = n1_sb;

  // Forward is the negated unit vector toward the camera.
  logic               f_v_r;
  logic [2:0][VW-1:0] fwd_r;
  logic [2:0][WW-1:0] f_scale_r;
  logic               f_deg_r;
  logic [2:0][VW-1:0] fwd_nxt;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      fwd_nxt[j] = n1_neg[j] ? {1'b0, n1_q[j]} : (~{1'b0, n1_q[j]} + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (en) begin
      f_v_r <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_r     <= fwd_nxt;
      f_scale_r <= n1_scale;
      f_deg_r   <= n1_zero;
    end
  end

  // Side vector (forward.z, 0, -forward.x) as sign and magnitude.
  logic [2:0][QW-1:0] s_mag;
  logic               s_neg0;
  logic               s_neg2;

  always_comb begin
    s_neg0   = fwd_r[2][VW-1];
    s_neg2   = ~fwd_r[0][VW-1];
    s_mag[0] = s_neg0 ? QW'(~fwd_r[2] + 1'b1) : QW'(fwd_r[2]);
    s_mag[1] = '0;
    s_mag[2] = fwd_r[0][VW-1] ? QW'(~fwd_r[0] + 1'b1) : QW'(fwd_r[0]);
  end

  logic               n2_v;
  logic [2:0][FW:0]   n2_q;
  logic               n2_zero;
  logic [SB2_W-1:0]   n2_sb;
  logic [2:0][VW-1:0] n2_fwd;
  logic [2:0][WW-1:0] n2_scale;
  logic               n2_deg1;
  logic               n2_neg0;
  logic               n2_neg2;

  bom_norm #(
    .MW (QW),
    .FW (FW),
    .SW (SB2_W)
  ) u_norm_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_v_r),
    .in_mag    (s_mag),
    .in_sb     ({fwd_r, f_scale_r, f_deg_r, s_neg0, s_neg2}),
    .out_valid (n2_v),
    .out_q     (n2_q),
    .out_zero  (n2_zero),
    .out_sb    (n2_sb)
  );

  assign {n2_fwd, n2_scale, n2_deg1, n2_neg0, n2_neg2} = n2_sb;

  // Right vector with signs restored.
  logic               r_v_r;
  logic [2:0][VW-1:0] r_right_r;
  logic [2:0][VW-1:0] r_fwd_r;
  logic [2:0][WW-1:0] r_scale_r;
  logic               r_deg_r;
  logic [2:0][VW-1:0] right_nxt;

  always_comb begin
    right_nxt[0] = n2_neg0 ? (~{1'b0, n2_q[0]} + 1'b1) : {1'b0, n2_q[0]};
    right_nxt[1] = {1'b0, n2_q[1]};
    right_nxt[2] = n2_neg2 ? (~{1'b0, n2_q[2]} + 1'b1) : {1'b0, n2_q[2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r <= 1'b0;
    end else if (en) begin
      r_v_r <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_right_r <= right_nxt;
      r_fwd_r   <= n2_fwd;
      r_scale_r <= n2_scale;
      r_deg_r   <= n2_deg1 | n2_zero;
    end
  end

  // Cross product terms for up = forward x right.
  logic                p_v_r;
  logic [5:0][PPW-1:0] p_r;
  logic [2:0][VW-1:0]  p_right_r;
  logic [2:0][VW-1:0]  p_fwd_r;
  logic [2:0][WW-1:0]  p_scale_r;
  logic                p_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= r_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= PPW'($signed(r_fwd_r[1])) * PPW'($signed(r_right_r[2]));
      p_r[1] <= PPW'($signed(r_fwd_r[2])) * PPW'($signed(r_right_r[1]));
      p_r[2] <= PPW'($signed(r_fwd_r[2])) * PPW'($signed(r_right_r[0]));
      p_r[3] <= PPW'($signed(r_fwd_r[0])) * PPW'($signed(r_right_r[2]));
      p_r[4] <= PPW'($signed(r_fwd_r[0])) * PPW'($signed(r_right_r[1]));
      p_r[5] <= PPW'($signed(r_fwd_r[1])) * PPW'($signed(r_right_r[0]));
      p_right_r <= r_right_r;
      p_fwd_r   <= r_fwd_r;
      p_scale_r <= r_scale_r;
      p_deg_r   <= r_deg_r;
    end
  end

  // Round each term, then take the differences.
  logic [2:0][UW-1:0] up_nxt;
  logic signed [MPW:0] up_d [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      up_d[j] = rnd_shift(MPW'($signed(p_r[2*j]))) - rnd_shift(MPW'($signed(p_r[2*j+1])));
      up_nxt[j] = UW'(up_d[j]);
    end
  end

  logic               u_v_r;
  logic [2:0][UW-1:0] u_up_r;
  logic [2:0][VW-1:0] u_right_r;
  logic [2:0][VW-1:0] u_fwd_r;
  logic [2:0][WW-1:0] u_scale_r;
  logic               u_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_v_r <= 1'b0;
    end else if (en) begin
      u_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_up_r    <= up_nxt;
      u_right_r <= p_right_r;
      u_fwd_r   <= p_fwd_r;
      u_scale_r <= p_scale_r;
      u_deg_r   <= p_deg_r;
    end
  end

  // Row scaling: right by scale x, up by scale y, forward by scale z.
  logic [8:0][UW-1:0] basis;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      basis[c]     = UW'($signed(u_right_r[c]));
      basis[3 + c] = u_up_r[c];
      basis[6 + c] = UW'($signed(u_fwd_r[c]));
    end
  end

  logic                m_v_r;
  logic [8:0][MPW-1:0] m_prod_r;
  logic                m_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= u_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        m_prod_r[e] <= MPW'($signed(u_scale_r[e / 3])) * MPW'($signed(basis[e]));
      end
      m_deg_r <= u_deg_r;
    end
  end

  // Round and saturate into the last pipeline register.
  logic               l_v_r;
  logic [8:0][WW-1:0] l_m_r;
  logic               l_deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_v_r <= 1'b0;
    end else if (en) begin
      l_v_r <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        l_m_r[e] <= sat_word(rnd_shift(m_prod_r[e]));
      end
      l_deg_r <= m_deg_r;
    end
  end

  // Output register plus one skid entry.
  logic               xfer;
  logic [8:0][WW-1:0] o_m_r;
  logic               o_deg_r;
  logic [8:0][WW-1:0] k_m_r;
  logic               k_deg_r;
  logic               o_free;

  assign xfer   = en && l_v_r;
  assign o_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (o_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= xfer;
      end
    end else if (xfer) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free) begin
      if (skid_v_r) begin
        o_m_r   <= k_m_r;
        o_deg_r <= k_deg_r;
      end else if (xfer) begin
        o_m_r   <= l_m_r;
        o_deg_r <= l_deg_r;
      end
    end else if (xfer) begin
      k_m_r   <= l_m_r;
      k_deg_r <= l_deg_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_m00        = o_m_r[0];
  assign out_m01        = o_m_r[1];
  assign out_m02        = o_m_r[2];
  assign out_m10        = o_m_r[3];
  assign out_m11        = o_m_r[4];
  assign out_m12        = o_m_r[5];
  assign out_m20        = o_m_r[6];
  assign out_m21        = o_m_r[7];
  assign out_m22        = o_m_r[8];
  assign out_degenerate = o_deg_r;

endmodule

`default_nettype wire
